// ===== rtl/core/ssid_pkg.sv =====
package ssid_pkg;

   localparam int DataWidth = 32;

   localparam logic [2:0] OP_INSERT    = 3'd0;
   localparam logic [2:0] OP_DELETE    = 3'd1;
   localparam logic [2:0] OP_DUMP_ASC  = 3'd2;
   localparam logic [2:0] OP_DUMP_DESC = 3'd3;
   localparam logic [2:0] OP_CLEAR     = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef logic signed [DataWidth-1:0] data_type;

   typedef struct packed {
      logic     insert_en;
      logic     delete_en;
      logic     rot_left;
      logic     rot_right;
      data_type key;
   } cell_ctl_type;

endpackage

// ===== rtl/core/ssid_cell.sv =====
module ssid_cell #(
   parameter int INDEX    = 0,
   parameter int CNTWIDTH = 6
) (
   input  logic                   clock,
   input  ssid_pkg::cell_ctl_type ctl,
   input  logic [CNTWIDTH-1:0]    count,
   input  logic                   left_lt,
   input  ssid_pkg::data_type     left_value,
   input  ssid_pkg::data_type     right_value,
   input  ssid_pkg::data_type     wrap_value,
   output ssid_pkg::data_type     value,
   output ssid_pkg::data_type     tail_value,
   output logic                   lt,
   output logic                   eq,
   output logic                   ge
);

   ssid_pkg::data_type value_ff;
   ssid_pkg::data_type value_in;
   logic               occupied;
   logic               is_last;

   assign occupied   = CNTWIDTH'(INDEX) < count;
   assign is_last    = count == CNTWIDTH'(INDEX + 1);
   assign lt         = occupied && (value_ff < ctl.key);
   assign eq         = occupied && (value_ff == ctl.key);
   assign ge         = occupied && !(value_ff < ctl.key);
   assign value      = value_ff;
   assign tail_value = is_last ? value_ff : '0;

   always_comb begin
      value_in = value_ff;
      priority if (ctl.insert_en) begin
         if (!left_lt) begin
            value_in = left_value;
         end else if (!lt) begin
            value_in = ctl.key;
         end
      end else if (ctl.delete_en) begin
         if (ge) begin
            value_in = right_value;
         end
      end else if (ctl.rot_left) begin
         value_in = is_last ? wrap_value : right_value;
      end else if (ctl.rot_right) begin
         value_in = (INDEX == 0) ? wrap_value : left_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/sorted_set_insert_delete_unit.sv =====
// Insert, delete and clear give a registered result word in the cycle after acceptance.
// A dump first enters the dump state; then the cell row rotates one place and a word is
// registered per cycle unless the receiver stalls; an empty set gives one ST_EMPTY word.
// The next command is accepted once the last word of a dump has left the cells.
// Reset (synchronous, active high) empties the set and drops any pending result;
// the cell contents are not reset.
module sorted_set_insert_delete_unit #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic        rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               dump_ff, dump_in;
   logic               dir_ff, dir_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   ssid_pkg::data_type rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   ssid_pkg::cell_ctl_type ctl;
   ssid_pkg::data_type     cell_value [CAPACITY];
   ssid_pkg::data_type     cell_tail [CAPACITY];
   logic [CAPACITY-1:0]    cell_lt;
   logic [CAPACITY-1:0]    cell_eq;
   logic [CAPACITY-1:0]    cell_ge;
   ssid_pkg::data_type     tail_value;
   ssid_pkg::data_type     wrap_value;

   logic out_free;
   logic accept;
   logic found;
   logic full;
   logic dump_step;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = dump_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign found     = |cell_eq;
   assign full      = count_ff == CW'(CAPACITY);
   assign dump_step = dump_ff && out_free;

   always_comb begin
      tail_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_value = tail_value | cell_tail[i];
      end
   end

   assign wrap_value = dir_ff ? tail_value : cell_value[0];

   always_comb begin
      ctl.key       = req_value;
      ctl.insert_en = accept && (req_opcode == ssid_pkg::OP_INSERT) && !found && !full;
      ctl.delete_en = accept && (req_opcode == ssid_pkg::OP_DELETE) && found;
      ctl.rot_left  = dump_step && !dir_ff;
      ctl.rot_right = dump_step && dir_ff;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ssid_cell #(
         .INDEX    (g),
         .CNTWIDTH (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .left_lt     ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
         .left_value  ((g == 0) ? '0 : cell_value[(g == 0) ? 0 : g - 1]),
         .right_value ((g == CAPACITY - 1) ? '0 : cell_value[(g == CAPACITY - 1) ? g : g + 1]),
         .wrap_value  (wrap_value),
         .value       (cell_value[g]),
         .tail_value  (cell_tail[g]),
         .lt          (cell_lt[g]),
         .eq          (cell_eq[g]),
         .ge          (cell_ge[g])
      );
   end

   always_comb begin
      count_in      = count_ff;
      dump_in       = dump_ff;
      dir_in        = dir_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (accept) begin
         unique case (req_opcode)
            ssid_pkg::OP_INSERT: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               if (found) begin
                  rsp_status_in = ssid_pkg::ST_DUP;
               end else if (full) begin
                  rsp_status_in = ssid_pkg::ST_FULL;
               end else begin
                  rsp_status_in = ssid_pkg::ST_OK;
                  count_in      = count_ff + 1'b1;
               end
            end
            ssid_pkg::OP_DELETE: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               if (found) begin
                  rsp_status_in = ssid_pkg::ST_OK;
                  count_in      = count_ff - 1'b1;
               end else begin
                  rsp_status_in = ssid_pkg::ST_NOTFOUND;
               end
            end
            ssid_pkg::OP_DUMP_ASC, ssid_pkg::OP_DUMP_DESC: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ssid_pkg::ST_EMPTY;
                  rsp_data_in   = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  dump_in   = 1'b1;
                  dir_in    = req_opcode == ssid_pkg::OP_DUMP_DESC;
                  remain_in = count_ff;
               end
            end
            ssid_pkg::OP_CLEAR: begin
               count_in      = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ssid_pkg::ST_OK;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (dump_step) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ssid_pkg::ST_OK;
         rsp_data_in   = wrap_value;
         rsp_last_in   = remain_ff == CW'(1);
         remain_in     = remain_ff - 1'b1;
         if (remain_ff == CW'(1)) begin
            dump_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dump_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dump_ff      <= dump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff        <= dir_in;
      remain_ff     <= remain_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last     = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      dump_ff |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("dump counter out of range");

   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      dump_ff |-> !accept)
      else $error("command accepted during dump");

   a_full_unchanged: assert property (@(posedge clock) disable iff (reset)
      (ctl.insert_en || ctl.delete_en) |=> $past(count_ff) != count_ff)
      else $error("insert or delete did not change the count");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      ctl.delete_en |-> (cell_ge != '0) && ((cell_eq & ~cell_ge) == '0))
      else $error("match found outside the upper part of the row");

endmodule

// ===== tb/sv/sorted_set_result_checker.sv =====
`timescale 1ns / 100ps

module sorted_set_result_checker #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  ssid_pkg::data_type req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_status,
   input  ssid_pkg::data_type rsp_data_out,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 words_awaited,
   output int                 words_checked
);

   typedef struct {
      logic [2:0]         status;
      ssid_pkg::data_type data;
      logic               last;
   } result_word_type;

   ssid_pkg::data_type set_values[CAPACITY];
   int                 set_size;
   result_word_type    awaited_words[$];
   int                 bad_words;
   int                 good_count;

   function automatic void await_word(logic [2:0] status, ssid_pkg::data_type data,
                                      logic last);
      result_word_type w;
      w.status = status;
      w.data   = data;
      w.last   = last;
      awaited_words.push_back(w);
   endfunction

   // Applies one accepted command to the shadow set and queues the words it must produce.
   function automatic void apply_command(logic [2:0] opcode, ssid_pkg::data_type value);
      int  pos;
      int  idx;
      bit  found;
      pos   = 0;
      found = 1'b0;
      case (opcode)
         ssid_pkg::OP_INSERT: begin
            while (pos < set_size && set_values[pos] < value) pos++;
            if (pos < set_size && set_values[pos] == value) begin
               await_word(ssid_pkg::ST_DUP, '0, 1'b1);
            end else if (set_size >= CAPACITY) begin
               await_word(ssid_pkg::ST_FULL, '0, 1'b1);
            end else begin
               for (int i = set_size; i > pos; i--) set_values[i] = set_values[i-1];
               set_values[pos] = value;
               set_size++;
               await_word(ssid_pkg::ST_OK, '0, 1'b1);
            end
         end
         ssid_pkg::OP_DELETE: begin
            for (int i = 0; i < set_size; i++) begin
               if (!found && set_values[i] == value) begin
                  found = 1'b1;
                  pos   = i;
               end
            end
            if (found) begin
               for (int i = pos; i + 1 < set_size; i++) set_values[i] = set_values[i+1];
               set_size--;
               await_word(ssid_pkg::ST_OK, '0, 1'b1);
            end else begin
               await_word(ssid_pkg::ST_NOTFOUND, '0, 1'b1);
            end
         end
         ssid_pkg::OP_DUMP_ASC, ssid_pkg::OP_DUMP_DESC: begin
            if (set_size == 0) begin
               await_word(ssid_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < set_size; i++) begin
                  idx = (opcode == ssid_pkg::OP_DUMP_ASC) ? i : set_size - 1 - i;
                  await_word(ssid_pkg::ST_OK, set_values[idx], i == set_size - 1);
               end
            end
         end
         ssid_pkg::OP_CLEAR: begin
            set_size = 0;
            await_word(ssid_pkg::ST_OK, '0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      result_word_type want;
      bit              ok;
      if (reset) begin
         set_size   = 0;
         bad_words  = 0;
         good_count = 0;
         awaited_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            good_count++;
            if (awaited_words.size() == 0) begin
               $error("unexpected result word: status %0d, data_out %0d, last %0d",
                      rsp_status, rsp_data_out, rsp_last);
               bad_words++;
            end else begin
               want = awaited_words.pop_front();
               ok   = 1'b1;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  ok = 1'b0;
               end
               if (rsp_data_out !== want.data) begin
                  $error("data_out: expected %0d, actual %0d", want.data, rsp_data_out);
                  ok = 1'b0;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  ok = 1'b0;
               end
               if (!ok) bad_words++;
            end
         end
         if (req_valid && !req_stall) apply_command(req_opcode, req_value);
      end
      mismatch_count <= bad_words;
      words_checked  <= good_count;
      words_awaited  <= awaited_words.size();
   end

endmodule

// ===== tb/sv/sorted_set_insert_delete_unit_tb.sv =====
`timescale 1ns / 100ps

module sorted_set_insert_delete_unit_tb;

   localparam int CAPACITY        = 32;
   localparam int RANDOM_COMMANDS = 400;

   localparam logic [2:0] OP_RESERVED_A = 3'd5;
   localparam logic [2:0] OP_RESERVED_B = 3'd6;
   localparam logic [2:0] OP_RESERVED_C = 3'd7;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_valid  = 1'b0;
   logic               req_stall;
   logic [2:0]         req_opcode = ssid_pkg::OP_INSERT;
   ssid_pkg::data_type req_value  = '0;
   logic               rsp_valid;
   logic               rsp_stall  = 1'b0;
   logic [2:0]         rsp_status;
   ssid_pkg::data_type rsp_data_out;
   logic               rsp_last;

   int mismatch_count;
   int words_awaited;
   int words_checked;

   int burst_left       = 1;
   int commands_sent    = 0;
   int stall_level      = 0;
   int stall_phase_left = 0;

   sorted_set_insert_delete_unit #(.CAPACITY(CAPACITY)) uut (.*);

   sorted_set_result_checker #(.CAPACITY(CAPACITY)) result_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver switches between stall probabilities from zero to three quarters.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_level      = $urandom_range(0, 3);
         stall_phase_left = $urandom_range(10, 80);
      end
      stall_phase_left--;
      rsp_stall <= ($urandom_range(0, 3) < stall_level);
   end

   task automatic send_command(input logic [2:0] opcode, input ssid_pkg::data_type value);
      req_valid  <= 1'b1;
      req_opcode <= opcode;
      req_value  <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (opcode <= ssid_pkg::OP_CLEAR) commands_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // Mostly a small pool so that duplicates and successful deletes are common.
   function automatic ssid_pkg::data_type pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return ssid_pkg::data_type'(int'($urandom_range(0, 47)) - 24);
      else if (roll < 7) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else return ssid_pkg::data_type'($urandom);
   endfunction

   initial begin
      int                 random_target;
      int                 insert_share;
      int                 roll;
      int                 drain_count;
      ssid_pkg::data_type base;
      int                 stride;
      logic [2:0]         dump_op;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_command(ssid_pkg::OP_DUMP_ASC, 32'sd0);
      send_command(ssid_pkg::OP_DUMP_DESC, -32'sd1);
      send_command(ssid_pkg::OP_DELETE, 32'sd5);
      send_command(ssid_pkg::OP_INSERT, 32'sh7FFF_FFFF);
      send_command(ssid_pkg::OP_INSERT, 32'sh8000_0000);
      send_command(ssid_pkg::OP_INSERT, 32'sd0);
      send_command(ssid_pkg::OP_INSERT, -32'sd1);
      send_command(ssid_pkg::OP_INSERT, 32'sd1);
      send_command(ssid_pkg::OP_INSERT, 32'sd0);
      send_command(ssid_pkg::OP_DUMP_ASC, 32'sd0);
      send_command(ssid_pkg::OP_DUMP_DESC, 32'sd0);
      send_command(ssid_pkg::OP_DELETE, 32'sd42);
      send_command(ssid_pkg::OP_DELETE, 32'sh8000_0000);
      send_command(ssid_pkg::OP_DELETE, 32'sh7FFF_FFFF);
      send_command(OP_RESERVED_A, 32'sd0);
      send_command(OP_RESERVED_B, 32'sd1);
      send_command(OP_RESERVED_C, -32'sd1);
      send_command(ssid_pkg::OP_DUMP_ASC, 32'sd0);
      send_command(ssid_pkg::OP_CLEAR, 32'sd9);
      send_command(ssid_pkg::OP_DUMP_DESC, 32'sd0);
      send_command(ssid_pkg::OP_CLEAR, 32'sd0);
      send_command(ssid_pkg::OP_INSERT, 32'sd7);
      send_command(ssid_pkg::OP_DELETE, 32'sd7);
      send_command(ssid_pkg::OP_DUMP_ASC, 32'sd0);

      random_target = commands_sent + RANDOM_COMMANDS;
      while (commands_sent < random_target) begin
         if ($urandom_range(0, 3) == 0) begin
            // Fill the set past capacity in scrambled order, then drain none, part or all of it.
            base   = ssid_pkg::data_type'($urandom);
            stride = $urandom_range(1, 50000);
            if ($urandom_range(0, 3) != 0) send_command(ssid_pkg::OP_CLEAR, pick_value());
            for (int j = 0; j < CAPACITY + 2; j++) begin
               send_command(ssid_pkg::OP_INSERT,
                            base + ssid_pkg::data_type'(((j * 13) % (CAPACITY + 2)) * stride));
            end
            send_command(ssid_pkg::OP_INSERT, base);
            send_command(ssid_pkg::OP_DUMP_ASC, pick_value());
            send_command(ssid_pkg::OP_DUMP_DESC, pick_value());
            drain_count = $urandom_range(0, CAPACITY + 1);
            for (int j = 0; j < drain_count; j++) begin
               send_command(ssid_pkg::OP_DELETE, base + ssid_pkg::data_type'(j * stride));
            end
            send_command(ssid_pkg::OP_DUMP_ASC, pick_value());
         end else begin
            case ($urandom_range(0, 2))
               0:       insert_share = 65;
               1:       insert_share = 40;
               default: insert_share = 15;
            endcase
            for (int j = 0; j < 30; j++) begin
               roll    = $urandom_range(0, 99);
               dump_op = $urandom_range(0, 1) ? ssid_pkg::OP_DUMP_ASC : ssid_pkg::OP_DUMP_DESC;
               if (roll < insert_share) send_command(ssid_pkg::OP_INSERT, pick_value());
               else if (roll < 80) send_command(ssid_pkg::OP_DELETE, pick_value());
               else if (roll < 92) send_command(dump_op, pick_value());
               else if (roll < 95) send_command(ssid_pkg::OP_CLEAR, pick_value());
               else send_command(3'($urandom_range(OP_RESERVED_A, OP_RESERVED_C)),
                                 pick_value());
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_awaited != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d commands and checked %0d result words.", commands_sent, words_checked);
      $display("Stimulus reached full sets, duplicates, misses, empty dumps and reserved opcodes.");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
